// File: design/range_coalescing_table_insert_macros.svh
// Assertion macros used by the range coalescing table sequencer.
`ifndef RANGE_COALESCING_TABLE_INSERT_MACROS_SVH
`define RANGE_COALESCING_TABLE_INSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted.
`define RCTI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define RCTI_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RCTI_ASSERT(lbl, prop, msg)
`define RCTI_NEVER(lbl, cond, msg)
`endif
`endif

// File: design/rcti_pkg.sv
// Shared types and constants of the range coalescing table.
package rcti_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ID_BITS     = 16;
	localparam int OFFSET_BITS = 24;
	localparam int IDX_W       = 7;
	localparam int RIDX_W      = 6;

	typedef logic [ID_BITS-1:0]     id_t;
	typedef logic [OFFSET_BITS-1:0] off_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [RIDX_W-1:0]      ridx_t;

	// Command codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic  command;
		idx_t  scan_from;
		id_t   handler_id;
		id_t   type_id;
		off_t  range_start;
		off_t  range_end;
		ridx_t read_index;
	} req_t;

	typedef struct packed {
		idx_t result_index;
		logic was_merged;
		logic table_full;
		id_t  entry_handler;
		id_t  entry_type;
		off_t entry_start;
		off_t entry_end;
		idx_t entry_total;
	} rsp_t;

	// One stored table entry
	typedef struct packed {
		id_t  hdl;
		id_t  typ;
		off_t start_off;
		off_t end_off;
	} entry_t;

endpackage

// File: design/range_coalescing_table_insert.sv
// Range coalescing table: request channel in, one response per request out.
//
// Requests arrive on req with req_valid/req_stall; a transfer happens at a clock
// edge with req_valid high and req_stall low. An add request scans entries from
// scan_from upward for one with the same handler and type whose end equals the
// new start, extends it, or else appends the new entry (dropped with table_full
// when the table holds TABLE_DEPTH entries). A read request returns one entry.
// Each request gives exactly one response on rsp with rsp_valid/rsp_stall.
// A read goes through the read-wait state to the finish state; an add scans
// and then finishes. Requests are handled one at a time; the entry memory's
// single read port compares one entry per cycle while scanning. A new request
// is taken the cycle after the previous response is loaded into the output
// register, even while that response is still held by rsp_stall; a stalled
// response holds its value. Reset empties the table at once (the count goes
// to zero); no clearing pass.

module range_coalescing_table_insert #(
	parameter int TABLE_DEPTH = rcti_pkg::TABLE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  rcti_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rcti_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	rcti_pkg::entry_t  rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	rcti_pkg::entry_t  wr_data;
	logic              res_valid;
	rcti_pkg::rsp_t    res;
	logic              res_ready;
	logic              rsp_valid_q;
	rcti_pkg::rsp_t    rsp_q;

	rcti_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	rcti_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register takes a new response when empty or being drained
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Load the response payload
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: design/rcti_table.sv
// Entry memory: one write port, one read port with registered read data.
module rcti_table #(
	parameter int TABLE_DEPTH = rcti_pkg::TABLE_DEPTH
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]  wr_addr,
	input  rcti_pkg::entry_t                wr_data,
	input  logic                            rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
	output rcti_pkg::entry_t                rd_data
);

	rcti_pkg::entry_t mem [TABLE_DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, hold data otherwise
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/rcti_ctrl.sv
// Sequencer: scans, appends or reads table entries and keeps the entry count.
`include "range_coalescing_table_insert_macros.svh"

module rcti_ctrl #(
	parameter int TABLE_DEPTH = rcti_pkg::TABLE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  rcti_pkg::req_t                  req,
	output logic                            req_stall,
	output logic                            rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
	input  rcti_pkg::entry_t                rd_data,
	output logic                            wr_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]  wr_addr,
	output rcti_pkg::entry_t                wr_data,
	output logic                            res_valid,
	output rcti_pkg::rsp_t                  res,
	input  logic                            res_ready
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int IW   = $clog2(TABLE_DEPTH + 1);
	localparam int CmpW = (IW > rcti_pkg::IDX_W) ? IW : rcti_pkg::IDX_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_RDWAIT = 4'b0100,
		S_FIN    = 4'b1000
	} state_t;

	state_t            state_q;
	rcti_pkg::req_t    item_q;
	logic [IW-1:0]     cnt_q;
	logic [IW-1:0]     rd_idx_q;
	logic [IW-1:0]     idx_s1;
	logic              pend_s1;
	logic              rd_ok_q;
	rcti_pkg::rsp_t    res_q;
	logic              wr_q;
	logic              inc_q;
	logic [AW-1:0]     wr_addr_q;
	rcti_pkg::entry_t  wr_data_q;

	logic              accept;
	logic              scan_in;
	logic              read_in;
	logic              hit;
	logic              more;
	logic              issue;
	logic              full;
	logic              fin_go;
	rcti_pkg::rsp_t    res_nxt;

	// Decode the incoming item against the current count
	always_comb begin
		accept  = req_valid && (state_q == S_IDLE);
		scan_in = CmpW'(req.scan_from) < CmpW'(cnt_q);
		read_in = CmpW'(req.read_index) < CmpW'(cnt_q);
		full    = (cnt_q == IW'(TABLE_DEPTH));
		fin_go  = (state_q == S_FIN) && res_ready;
	end

	// Compare the entry read last cycle; issue the next read while no match
	always_comb begin
		hit = pend_s1 && (rd_data.hdl == item_q.handler_id) &&
			(rd_data.typ == item_q.type_id) && (rd_data.end_off == item_q.range_start);
		more  = rd_idx_q < cnt_q;
		issue = (state_q == S_SCAN) && !hit && more;
	end

	// Memory port drive; reads and writes never share a state, so no forwarding
	always_comb begin
		rd_en   = (accept && (req.command == rcti_pkg::CMD_READ) && read_in) || issue;
		rd_addr = accept ? AW'(req.read_index) : rd_idx_q[AW-1:0];
		wr_en   = fin_go && wr_q;
		wr_addr = wr_addr_q;
		wr_data = wr_data_q;
	end

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN);

	// Attach the count after this item to the result
	always_comb begin
		res = res_q;
		res.entry_total = rcti_pkg::idx_t'(cnt_q + IW'(inc_q));
	end

	// Build the result of a finished read or scan; zero the entry past the count
	always_comb begin
		res_nxt = '0;
		if (state_q == S_RDWAIT) begin
			if (rd_ok_q) begin
				res_nxt.entry_handler = rd_data.hdl;
				res_nxt.entry_type    = rd_data.typ;
				res_nxt.entry_start   = rd_data.start_off;
				res_nxt.entry_end     = rd_data.end_off;
			end
		end else if (hit) begin
			res_nxt.result_index = rcti_pkg::idx_t'(idx_s1);
			res_nxt.was_merged   = 1'b1;
		end else begin
			res_nxt.result_index = rcti_pkg::idx_t'(cnt_q);
			res_nxt.table_full   = full;
		end
	end

	// Advance the sequencer and the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (req_valid) begin
						state_q <= (req.command == rcti_pkg::CMD_READ) ? S_RDWAIT : S_SCAN;
					end
				end
				S_SCAN: begin
					pend_s1 <= issue;
					if (hit || !more) begin
						state_q <= S_FIN;
					end
				end
				S_RDWAIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
						if (inc_q) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the item, walk the scan index and hold the result
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= req;
			rd_idx_q <= scan_in ? IW'(req.scan_from) : cnt_q;
			rd_ok_q  <= read_in;
		end
		if (issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
			idx_s1   <= rd_idx_q;
		end
		if ((state_q == S_SCAN) && (hit || !more)) begin
			res_q <= res_nxt;
			if (hit) begin
				// Extend the matching entry
				wr_q               <= 1'b1;
				inc_q              <= 1'b0;
				wr_addr_q          <= idx_s1[AW-1:0];
				wr_data_q          <= '{hdl: rd_data.hdl, typ: rd_data.typ,
					start_off: rd_data.start_off, end_off: item_q.range_end};
			end else begin
				wr_q               <= !full;
				inc_q              <= !full;
				wr_addr_q          <= cnt_q[AW-1:0];
				wr_data_q          <= '{hdl: item_q.handler_id, typ: item_q.type_id,
					start_off: item_q.range_start, end_off: item_q.range_end};
			end
		end
		if (state_q == S_RDWAIT) begin
			// Return the entry read at the transfer
			res_q <= res_nxt;
			wr_q  <= 1'b0;
			inc_q <= 1'b0;
		end
	end

	`RCTI_NEVER(a_cnt_bound, cnt_q > IW'(TABLE_DEPTH), "entry count above table depth")
	`RCTI_ASSERT(a_wr_in_fin, wr_en |-> (state_q == S_FIN), "table written outside finish")
	`RCTI_ASSERT(a_merge_idx, (res_valid && res_q.was_merged) |-> (!inc_q && (CmpW'(res_q.result_index) < CmpW'(cnt_q))), "merge index beyond count")
	`RCTI_ASSERT(a_cnt_step, (fin_go && inc_q) |=> (cnt_q == $past(cnt_q) + 1'b1), "count did not advance on append")
	`RCTI_ASSERT(a_busy_after_accept, accept |=> (state_q != S_IDLE), "item accepted without work")

endmodule

// File: tb/rcti_checker.sv
// Scoreboard for the range coalescing table: mirrors the table, predicts and compares responses.
module rcti_checker
	import rcti_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	entry_t table_mirror [TABLE_DEPTH];
	int     fill_count;
	rsp_t   awaited_rsp [$];
	int     err_count = 0;

	// Apply one command to the mirrored table and return the response it must give
	function automatic rsp_t apply_table_cmd(input req_t r);
		rsp_t o;
		bit   hit;
		int   i;
		o = '0;
		hit = 1'b0;
		if (r.command == CMD_ADD) begin
			// find the first entry, from scan_from up, whose end meets the new start
			for (i = int'(r.scan_from); i < fill_count && !hit; i++) begin
				if (table_mirror[i].hdl == r.handler_id && table_mirror[i].typ == r.type_id &&
				    table_mirror[i].end_off == r.range_start) begin
					table_mirror[i].end_off = r.range_end;
					o.result_index = idx_t'(i);
					o.was_merged = 1'b1;
					hit = 1'b1;
				end
			end
			// no merge: append, or drop when the table is full
			if (!hit) begin
				if (fill_count < TABLE_DEPTH) begin
					table_mirror[fill_count].hdl = r.handler_id;
					table_mirror[fill_count].typ = r.type_id;
					table_mirror[fill_count].start_off = r.range_start;
					table_mirror[fill_count].end_off = r.range_end;
					o.result_index = idx_t'(fill_count);
					fill_count++;
				end else begin
					o.table_full = 1'b1;
					o.result_index = idx_t'(fill_count);
				end
			end
		end else if (int'(r.read_index) < fill_count) begin
			o.entry_handler = table_mirror[r.read_index].hdl;
			o.entry_type = table_mirror[r.read_index].typ;
			o.entry_start = table_mirror[r.read_index].start_off;
			o.entry_end = table_mirror[r.read_index].end_off;
		end
		o.entry_total = idx_t'(fill_count);
		return o;
	endfunction

	// Compare one response transfer against the oldest prediction
	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		bit   bad;
		if (awaited_rsp.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("ERROR %0t: response transfer with nothing expected, got %h", $realtime, got);
		end else begin
			want = awaited_rsp.pop_front();
			bad = (got.result_index !== want.result_index) || (got.was_merged !== want.was_merged) ||
			      (got.table_full !== want.table_full) || (got.entry_handler !== want.entry_handler) ||
			      (got.entry_type !== want.entry_type) || (got.entry_start !== want.entry_start) ||
			      (got.entry_end !== want.entry_end) || (got.entry_total !== want.entry_total);
			if (bad) begin
				err_count++;
				if (err_count <= 10)
					$display("ERROR %0t: exp idx %0d merged %0b full %0b hdl %h typ %h ",
					         $realtime, want.result_index, want.was_merged, want.table_full,
					         want.entry_handler, want.entry_type,
					         "start %h end %h total %0d / got idx %0d merged %0b full %0b ",
					         want.entry_start, want.entry_end, want.entry_total,
					         got.result_index, got.was_merged, got.table_full,
					         "hdl %h typ %h start %h end %h total %0d",
					         got.entry_handler, got.entry_type, got.entry_start,
					         got.entry_end, got.entry_total);
			end
		end
	endtask

	// Watch both channels; check responses before queuing the request of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count = 0;
			awaited_rsp.delete();
		end else begin
			if (rsp_valid && !rsp_stall)
				check_rsp(rsp);
			if (req_valid && !req_stall)
				awaited_rsp.push_back(apply_table_cmd(req));
		end
		mismatches <= err_count;
		outstanding <= awaited_rsp.size();
	end

endmodule

// File: tb/tb_range_coalescing_table_insert.sv
// Top of the range coalescing table testbench: clock, reset, stimulus and verdict.
module tb_range_coalescing_table_insert;
	import rcti_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_ITEMS = 1930;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int   mismatches;
	int   outstanding;

	// recently sent adds, used to build ranges that chain onto stored entries
	id_t  recent_hdl [16];
	id_t  recent_typ [16];
	off_t recent_end [16];
	int   recent_wr = 0;
	int   recent_fill = 0;
	int   burst_left = 1;

	stall_mode_e stall_mode = STALL_NONE;
	int          stall_tick = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	range_coalescing_table_insert dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	rcti_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Switch the response stall pattern now and then
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 200 == 0)
			stall_mode = stall_mode_e'($urandom_range(0, 2));
		case (stall_mode)
			STALL_NONE:   rsp_stall <= 1'b0;
			STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
			default:      rsp_stall <= ((stall_tick % 7) < 4);
		endcase
	end

	function automatic req_t add_req(input idx_t from, input id_t h, input id_t t,
	                                 input off_t s, input off_t e);
		req_t r;
		r = '0;
		r.command = CMD_ADD;
		r.scan_from = from;
		r.handler_id = h;
		r.type_id = t;
		r.range_start = s;
		r.range_end = e;
		return r;
	endfunction

	function automatic req_t read_req(input ridx_t i);
		req_t r;
		r = '0;
		r.command = CMD_READ;
		r.read_index = i;
		return r;
	endfunction

	// Ids mostly from a small pool so that entries collide and merge
	function automatic id_t pick_id();
		case ($urandom_range(0, 4))
			0:       return 16'h0000;
			1:       return 16'h0001;
			2:       return 16'hFFFF;
			3:       return 16'h5A5A;
			default: return id_t'($urandom);
		endcase
	endfunction

	// Random item: reads, adds chained onto earlier ranges, and free adds
	function automatic req_t make_random();
		req_t r;
		int   pick;
		int   k;
		r.command = CMD_ADD;
		r.scan_from = ($urandom_range(0, 9) < 6) ? idx_t'(0) : idx_t'($urandom_range(0, 64));
		r.handler_id = pick_id();
		r.type_id = pick_id();
		r.range_start = off_t'($urandom);
		r.range_end = off_t'($urandom);
		r.read_index = ridx_t'($urandom_range(0, 63));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.command = CMD_READ;
		end else if (pick < 80 && recent_fill > 0) begin
			k = $urandom_range(0, recent_fill - 1);
			r.handler_id = recent_hdl[k];
			r.type_id = recent_typ[k];
			r.range_start = recent_end[k];
			if ($urandom_range(0, 3) == 0)
				r.scan_from = idx_t'($urandom_range(0, 64));
			else
				r.scan_from = '0;
			if ($urandom_range(0, 1) == 0)
				r.range_end = recent_end[k] + off_t'($urandom_range(1, 256));
		end
		return r;
	endfunction

	// Drive one request until its transfer, then idle between bursts
	task automatic send_item(input req_t r);
		int gap;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (r.command == CMD_ADD) begin
			recent_hdl[recent_wr] = r.handler_id;
			recent_typ[recent_wr] = r.type_id;
			recent_end[recent_wr] = r.range_end;
			recent_wr = (recent_wr + 1) % 16;
			if (recent_fill < 16)
				recent_fill++;
		end
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
		end
	endtask

	initial begin
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads of an empty table
		send_item(read_req(6'd0));
		send_item(read_req(6'd63));
		// appends at the field extremes, one with the scan start past the count
		send_item(add_req(7'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'h000000));
		send_item(add_req(7'd64, 16'h0000, 16'h0000, 24'h000000, 24'hFFFFFF));
		// extend entry 0, then extend it with an end below its start
		send_item(add_req(7'd0, 16'hFFFF, 16'hFFFF, 24'h000000, 24'h000010));
		send_item(add_req(7'd0, 16'hFFFF, 16'hFFFF, 24'h000010, 24'h000005));
		// match sits below the scan start: append instead
		send_item(add_req(7'd1, 16'hFFFF, 16'hFFFF, 24'h000005, 24'h000020));
		// same end but different type, with handler FFFF and then with handler 0000
		send_item(add_req(7'd0, 16'hFFFF, 16'h0000, 24'h000005, 24'h000007));
		send_item(add_req(7'd0, 16'h0000, 16'hFFFF, 24'hFFFFFF, 24'h000001));
		// match exactly at the scan start
		send_item(add_req(7'd1, 16'h0000, 16'h0000, 24'hFFFFFF, 24'h123456));
		// read back stored entries and two past the count
		send_item(read_req(6'd0));
		send_item(read_req(6'd1));
		send_item(read_req(6'd2));
		send_item(read_req(6'd4));
		send_item(read_req(6'd5));
		send_item(read_req(6'd63));

		repeat (RANDOM_ITEMS) send_item(make_random());

		// drain the outstanding responses, then watch for strays
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stop a hung run
	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
